### design/assert_macros.svh
// Assertion macros shared by the speed controller RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted
`define RCMS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked assertion that is checked during reset as well
`define RCMS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### design/rcms_pkg.sv
// Types and constants of the motor speed controller
package rcms_pkg;

	typedef enum logic [2:0] {
		CMD_PULSE    = 3'd0,
		CMD_OVERFLOW = 3'd1,
		CMD_TICK     = 3'd2,
		CMD_TEMP     = 3'd3,
		CMD_POSITION = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_FWD   = 2'd0,
		MODE_BRAKE = 2'd1,
		MODE_BWD   = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		TEMP_COOL = 2'd0,
		TEMP_WARM = 2'd1,
		TEMP_HOT  = 2'd2
	} temp_t;

	typedef enum logic [1:0] {
		POS_TOP    = 2'd0,
		POS_MIDDLE = 2'd1,
		POS_BOTTOM = 2'd2
	} pos_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_DIV  = 2'd1,
		ST_OUT  = 2'd2
	} state_t;

	localparam logic [2:0] REG_PULSE_MIN = 3'd0;
	localparam logic [2:0] REG_PULSE_MAX = 3'd1;
	localparam logic [2:0] REG_POS_MIN   = 3'd2;
	localparam logic [2:0] REG_POS_MAX   = 3'd3;
	localparam logic [2:0] REG_TEMP_HOT  = 3'd4;
	localparam logic [2:0] REG_TEMP_WARM = 3'd5;

	localparam int unsigned CFG_W  = 16;
	localparam int unsigned REM_W  = 26;
	localparam int unsigned QUO_W  = 15;
	localparam int unsigned STEP_W = 4;

	localparam logic [STEP_W-1:0] PULSE_TOP_STEP = 4'd9;
	localparam logic [STEP_W-1:0] POS_TOP_STEP   = 4'd14;

	localparam logic [7:0]        MAX_SLEW    = 8'd30;
	localparam logic [4:0]        FAULT_LEVEL = 5'd15;
	localparam logic [4:0]        COUNT_CAP   = 5'd30;
	localparam logic signed [8:0] WARM_LIMIT  = 9'sd128;
	localparam logic signed [10:0] VEL_OFFSET = 11'sd260;
	localparam logic signed [10:0] DEAD_BAND  = 11'sd5;
	localparam logic [14:0]       PCT_TOP     = 15'd90;
	localparam logic [14:0]       PCT_BOTTOM  = 15'd10;

endpackage

### design/rcms_if.sv
// Event and result channel interfaces of the motor speed controller
interface rcms_event_if;
	logic        valid;
	logic        ready;
	logic [2:0]  command;
	logic [15:0] pulse_width;
	logic [7:0]  sample_value;

	modport source (output valid, command, pulse_width, sample_value, input ready);
	modport sink (input valid, command, pulse_width, sample_value, output ready);
endinterface

interface rcms_result_if;
	logic              valid;
	logic              ready;
	logic [1:0]        bridge_mode;
	logic [7:0]        duty;
	logic signed [8:0] velocity_request;
	logic [1:0]        temp_level;
	logic [1:0]        end_stop;
	logic              fault;

	modport source (output valid, bridge_mode, duty, velocity_request, temp_level, end_stop,
		fault, input ready);
	modport sink (input valid, bridge_mode, duty, velocity_request, temp_level, end_stop,
		fault, output ready);
endinterface

### design/rc_motor_speed_controller.sv
// Brushed motor speed controller: event decoding, limiting and duty slew
//
// Usage: events enter on the valid/ready channel "events" (command, pulse_width,
// sample_value); every accepted beat yields exactly one beat on "results", which
// shows bridge mode, duty, decoded velocity, temperature level, end stop and fault
// as they stand after the event. Registers are set through wr_en/wr_index/wr_data;
// the user must write them only while the block is idle; the block does not enforce it.
// A valid pulse with a nonzero range and a position sample with unequal limits
// pass through the shared restoring divider (one quotient bit per cycle, 10 bits
// for pulses, 15 for position percent); other events go straight to the output
// state. The block takes one event at a time: a new event is accepted only once
// the result of the last one has been loaded into the output register.
// The result sits in an output register; a new event is accepted while it waits,
// but its state update is applied only once the pending beat has left, so a
// stalled receiver stalls the block without losing or repeating results.
// Reset: registers return to their defaults, the bridge brakes, duty and velocity
// are zero, temperature is cool and the position is middle.
`include "assert_macros.svh"

module rc_motor_speed_controller
	import rcms_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [2:0]          wr_index,
	input  logic [CFG_W-1:0]    wr_data,
	rcms_event_if.sink          events,
	rcms_result_if.source       results
);

	logic [15:0] pulse_min_q, pulse_max_q;
	logic [7:0]  pos_min_q, pos_max_q, temp_hot_q, temp_warm_q;

	state_t state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic [REM_W-1:0]  rem_q;
	logic [15:0]       div_q;
	logic [QUO_W-1:0]  quot_q;
	cmd_t              cmd_q;
	logic [15:0]       pw_q;
	logic [7:0]        smp_q;
	logic              res_valid_q;

	logic signed [8:0] vel_q, vel_d;
	logic [4:0]        tmo_q, tmo_d, fs_q, fs_d;
	temp_t             temp_q, temp_d;
	pos_t              pos_q, pos_d;
	mode_t             mode_q, mode_d;
	logic [7:0]        duty_q, duty_d;

	logic accept, fire, go_div;
	logic in_pulse_ok, out_pulse_ok;
	logic [15:0] in_span, out_span, pw_off;
	logic [7:0]  in_num_mag, in_den_mag, out_den_mag;
	logic [REM_W-1:0] pulse_num, pos_num, dsh;
	logic ge, pos_neg, fault;

	// tick datapath
	logic signed [8:0] lim_v;
	mode_t want;
	logic [7:0] speed;
	logic [8:0] duty_up;
	logic signed [10:0] map_v;

	assign accept = events.valid && events.ready;
	assign fire   = (state_q == ST_OUT) && (!res_valid_q || results.ready);
	assign events.ready = (state_q == ST_IDLE);

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_min_q <= 16'd2000;
			pulse_max_q <= 16'd4000;
			pos_min_q   <= 8'd0;
			pos_max_q   <= 8'd255;
			temp_hot_q  <= 8'd170;
			temp_warm_q <= 8'd180;
		end else if (wr_en) begin
			case (wr_index)
				REG_PULSE_MIN: pulse_min_q <= wr_data;
				REG_PULSE_MAX: pulse_max_q <= wr_data;
				REG_POS_MIN:   pos_min_q   <= wr_data[7:0];
				REG_POS_MAX:   pos_max_q   <= wr_data[7:0];
				REG_TEMP_HOT:  temp_hot_q  <= wr_data[7:0];
				REG_TEMP_WARM: temp_warm_q <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	// divider operand setup at accept
	assign in_pulse_ok = (events.pulse_width >= pulse_min_q) && (events.pulse_width <= pulse_max_q);
	assign in_span     = pulse_max_q - pulse_min_q;
	assign pw_off      = events.pulse_width - pulse_min_q;
	assign pulse_num   = ({10'd0, pw_off} << 9) + ({10'd0, pw_off} << 3);
	assign in_num_mag  = (events.sample_value >= pos_min_q) ? events.sample_value - pos_min_q
		: pos_min_q - events.sample_value;
	assign in_den_mag  = (pos_max_q >= pos_min_q) ? pos_max_q - pos_min_q : pos_min_q - pos_max_q;
	assign pos_num     = ({18'd0, in_num_mag} << 6) + ({18'd0, in_num_mag} << 5)
		+ ({18'd0, in_num_mag} << 2);

	always_comb begin
		go_div = 1'b0;
		case (cmd_t'(events.command))
			CMD_PULSE:    go_div = in_pulse_ok && (in_span != 16'd0);
			CMD_POSITION: go_div = (in_den_mag != 8'd0);
			default:      go_div = 1'b0;
		endcase
	end

	// shared compare/subtract unit
	assign dsh = {10'd0, div_q} << step_q;
	assign ge  = (rem_q >= dsh);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept) state_d = go_div ? ST_DIV : ST_OUT;
			ST_DIV:  if (step_q == '0) state_d = ST_OUT;
			ST_OUT:  if (fire) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fire) res_valid_q <= 1'b1;
			else if (results.ready) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= cmd_t'(events.command);
			pw_q   <= events.pulse_width;
			smp_q  <= events.sample_value;
			quot_q <= '0;
			if (cmd_t'(events.command) == CMD_POSITION) begin
				rem_q  <= pos_num;
				div_q  <= {8'd0, in_den_mag};
				step_q <= POS_TOP_STEP;
			end else begin
				rem_q  <= pulse_num;
				div_q  <= in_span;
				step_q <= PULSE_TOP_STEP;
			end
		end else if (state_q == ST_DIV) begin
			rem_q  <= ge ? rem_q - dsh : rem_q;
			quot_q <= {quot_q[QUO_W-2:0], ge};
			step_q <= step_q - 1'b1;
		end
	end

	// state update applied when the result is loaded
	assign out_pulse_ok = (pw_q >= pulse_min_q) && (pw_q <= pulse_max_q);
	assign out_span     = pulse_max_q - pulse_min_q;
	assign out_den_mag  = (pos_max_q >= pos_min_q) ? pos_max_q - pos_min_q : pos_min_q - pos_max_q;
	assign pos_neg      = (smp_q < pos_min_q) ^ (pos_max_q < pos_min_q);
	assign fault        = (tmo_q >= FAULT_LEVEL) || (fs_q >= FAULT_LEVEL);
	assign map_v = (out_span == 16'd0) ? 11'sd0 : $signed({1'b0, quot_q[9:0]}) - VEL_OFFSET;

	always_comb begin
		lim_v = vel_q;
		if (temp_q == TEMP_WARM) begin
			if (lim_v > WARM_LIMIT) lim_v = WARM_LIMIT;
			if (lim_v < -WARM_LIMIT) lim_v = -WARM_LIMIT;
		end
		if (temp_q == TEMP_HOT) lim_v = '0;
		if (lim_v > 9'sd0 && pos_q == POS_TOP) lim_v = '0;
		if (lim_v < 9'sd0 && pos_q == POS_BOTTOM) lim_v = '0;
		if (fault) lim_v = '0;
		if (lim_v < 9'sd0) begin
			want  = MODE_BWD;
			speed = 8'(-lim_v);
		end else if (lim_v > 9'sd0) begin
			want  = MODE_FWD;
			speed = lim_v[7:0];
		end else begin
			want  = MODE_BRAKE;
			speed = 8'd0;
		end
	end

	assign duty_up = {1'b0, duty_q} + {1'b0, MAX_SLEW};

	always_comb begin
		vel_d  = vel_q;
		tmo_d  = tmo_q;
		fs_d   = fs_q;
		temp_d = temp_q;
		pos_d  = pos_q;
		mode_d = mode_q;
		duty_d = duty_q;
		case (cmd_q)
			CMD_PULSE: begin
				if (out_pulse_ok) begin
					if (map_v >= -DEAD_BAND && map_v <= DEAD_BAND) vel_d = '0;
					else if (map_v > 11'sd0) vel_d = 9'(map_v - DEAD_BAND);
					else vel_d = 9'(map_v + DEAD_BAND);
					tmo_d = (tmo_q < 5'd3) ? 5'd0 : tmo_q - 5'd3;
					fs_d  = (fs_q < 5'd3) ? 5'd0 : fs_q - 5'd3;
				end else if (fs_q < COUNT_CAP) begin
					fs_d = fs_q + 5'd1;
				end
			end
			CMD_OVERFLOW: if (tmo_q < COUNT_CAP) tmo_d = tmo_q + 5'd1;
			CMD_TICK: begin
				if (want != mode_q) begin
					if (mode_q == MODE_BRAKE) begin
						mode_d = want;
					end else if (duty_q > MAX_SLEW) begin
						duty_d = duty_q - MAX_SLEW;
					end else begin
						duty_d = 8'd0;
						mode_d = MODE_BRAKE;
					end
				end else if (speed > duty_q) begin
					duty_d = ({1'b0, speed} > duty_up) ? duty_up[7:0] : speed;
				end else if (speed < duty_q) begin
					if (duty_q >= MAX_SLEW && speed < duty_q - MAX_SLEW) duty_d = duty_q - MAX_SLEW;
					else duty_d = speed;
				end
			end
			CMD_TEMP: begin
				if (smp_q < temp_hot_q) temp_d = TEMP_HOT;
				else if (smp_q < temp_warm_q) temp_d = TEMP_WARM;
			end
			CMD_POSITION: begin
				if (out_den_mag == 8'd0) pos_d = POS_MIDDLE;
				else if (pos_neg) pos_d = POS_BOTTOM;
				else if (quot_q > PCT_TOP) pos_d = POS_TOP;
				else if (quot_q < PCT_BOTTOM) pos_d = POS_BOTTOM;
				else pos_d = POS_MIDDLE;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vel_q  <= '0;
			tmo_q  <= '0;
			fs_q   <= '0;
			temp_q <= TEMP_COOL;
			pos_q  <= POS_MIDDLE;
			mode_q <= MODE_BRAKE;
			duty_q <= '0;
		end else if (fire) begin
			vel_q  <= vel_d;
			tmo_q  <= tmo_d;
			fs_q   <= fs_d;
			temp_q <= temp_d;
			pos_q  <= pos_d;
			mode_q <= mode_d;
			duty_q <= duty_d;
		end
	end

	assign results.valid            = res_valid_q;
	assign results.bridge_mode      = mode_q;
	assign results.duty             = duty_q;
	assign results.velocity_request = vel_q;
	assign results.temp_level       = temp_q;
	assign results.end_stop         = pos_q;
	assign results.fault            = fault;

	`RCMS_ASSERT(a_counts_capped, (tmo_q <= COUNT_CAP) && (fs_q <= COUNT_CAP), "counter above cap")
	`RCMS_ASSERT(a_no_direct_reverse, (mode_q == MODE_FWD) |=> (mode_q != MODE_BWD), "forward to backward without brake")
	`RCMS_ASSERT(a_pulse_quot_range, (state_q == ST_OUT && cmd_q == CMD_PULSE) |-> (quot_q <= 15'd520), "pulse quotient out of range")
	`RCMS_ASSERT(a_state_holds_on_stall, (res_valid_q && !results.ready) |=> $stable(duty_q) && $stable(mode_q), "state moved under pending result")

endmodule
